// ===== rtl/cde_pkg.sv =====
// ----------------------------------------------------------------------------
// cde_pkg
// shared types for the circular deque engine: command, status and
// sequencer state codes
// ----------------------------------------------------------------------------
package cde_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_FRONT = 3'd4,
    CMD_READ_BACK  = 3'd5,
    CMD_SEARCH     = 3'd6,
    CMD_UPDATE     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BAD_INDEX = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

endpackage

// ===== rtl/cde_ram.sv =====
// ----------------------------------------------------------------------------
// cde_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module cde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // read data holds while no read is issued
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/circular_deque_engine_unit.sv =====
// ----------------------------------------------------------------------------
// circular_deque_engine_unit
// double-ended queue of signed 32-bit words in a circular ram
// ----------------------------------------------------------------------------
// Usage: requests come in on the input channel (command_i, operand_value_i,
// position_i with in_valid_i / in_ready_o); every request gives exactly one
// result on the output channel (status_o, result_value_o, found_position_o,
// element_count_o, is_empty_o, is_full_o with out_valid_o / out_ready_i).
// A request is taken in the idle state, in which the ram read for it is
// issued, and executed in the exec state, which loads the output register
// once that register is free. A search walks the ram one entry per cycle
// from the front and stops at the first match or at the last element; on
// an empty deque it ends at once. One request is in flight at a time, so
// a new request is not taken before the last one has been executed.
// Reset empties the deque (head, tail and count to zero) and drops any
// pending result. While the receiver stalls, one result waits in the output
// register and the next request is still taken; its execution then waits
// until the output register is free.
// ----------------------------------------------------------------------------
module circular_deque_engine_unit
  import cde_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] operand_value_i,
  input  logic [3:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] result_value_o,
  output logic [3:0]         found_position_o,
  output logic [4:0]         element_count_o,
  output logic               is_empty_o,
  output logic               is_full_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((AW > 4) ? AW : 4) + 1;
  localparam int PW = (CW > 4) ? CW : 4;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
    if (s == AW'(DEPTH - 1)) begin
      slot_next = '0;
    end else begin
      slot_next = s + AW'(1);
    end
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
    if (s == '0) begin
      slot_prev = AW'(DEPTH - 1);
    end else begin
      slot_prev = s - AW'(1);
    end
  endfunction

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic [AW-1:0]    k_q, k_d;

  cmd_e             req_cmd_q;
  logic [31:0]      req_val_q;
  logic [3:0]       req_pos_q;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [31:0]      out_value_q;
  logic [3:0]       out_fpos_q;
  logic [4:0]       out_count_q;
  logic             out_empty_q;
  logic             out_full_q;

  logic             accept;
  logic             out_free;
  logic             commit;
  status_e          res_status;
  logic [31:0]      res_value;
  logic [3:0]       res_fpos;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [31:0]      ram_rd_data;

  logic [SW-1:0]    upd_sum;
  logic [AW-1:0]    upd_slot;
  logic             upd_ok;
  logic             is_last;
  logic [AW+3:0]    k_ext;
  logic [CW+4:0]    cnt_ext;

  cde_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(req_val_q),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // slot of a position counted from the front; pos < count keeps it below 2*DEPTH
  always_comb begin
    upd_sum = SW'(head_q) + SW'(req_pos_q);
    if (upd_sum >= SW'(DEPTH)) begin
      upd_sum = upd_sum - SW'(DEPTH);
    end
    upd_slot = upd_sum[AW-1:0];
  end

  assign upd_ok  = PW'(req_pos_q) < PW'(count_q);
  assign is_last = (CW'(k_q) + CW'(1)) == count_q;
  assign k_ext   = (AW + 4)'(k_q);
  assign cnt_ext = (CW + 5)'(count_d);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    scan_d      = scan_q;
    k_d         = k_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = head_q;
    ram_rd_en   = 1'b0;
    ram_rd_addr = head_q;
    commit      = 1'b0;
    res_status  = STAT_OK;
    res_value   = '0;
    res_fpos    = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // issue the read the request needs so data is there next cycle
          ram_rd_en = 1'b1;
          if (command_i == CMD_POP_BACK || command_i == CMD_READ_BACK) begin
            ram_rd_addr = tail_q;
          end else begin
            ram_rd_addr = head_q;
          end
          scan_d  = head_q;
          k_d     = '0;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (req_cmd_q == CMD_SEARCH && count_q != '0 && ram_rd_data != req_val_q &&
            !is_last) begin
          // no match yet: step to the next entry
          ram_rd_en   = 1'b1;
          ram_rd_addr = slot_next(scan_q);
          scan_d      = slot_next(scan_q);
          k_d         = k_q + AW'(1);
        end else if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
          case (req_cmd_q)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (count_q == CW'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                ram_wr_en = 1'b1;
                if (count_q == '0) begin
                  head_d      = '0;
                  tail_d      = '0;
                  ram_wr_addr = '0;
                end else if (req_cmd_q == CMD_PUSH_FRONT) begin
                  head_d      = slot_prev(head_q);
                  ram_wr_addr = slot_prev(head_q);
                end else begin
                  tail_d      = slot_next(tail_q);
                  ram_wr_addr = slot_next(tail_q);
                end
                count_d = count_q + CW'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_value = ram_rd_data;
                count_d   = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  head_d = '0;
                  tail_d = '0;
                end else if (req_cmd_q == CMD_POP_FRONT) begin
                  head_d = slot_next(head_q);
                end else begin
                  tail_d = slot_prev(tail_q);
                end
              end
            end
            CMD_READ_FRONT, CMD_READ_BACK: begin
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_value = ram_rd_data;
              end
            end
            CMD_SEARCH: begin
              if (count_q != '0 && ram_rd_data == req_val_q) begin
                res_fpos = k_ext[3:0];
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            CMD_UPDATE: begin
              if (upd_ok) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = upd_slot;
              end else begin
                res_status = STAT_BAD_INDEX;
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    k_q    <= k_d;
    if (accept) begin
      req_cmd_q <= cmd_e'(command_i);
      req_val_q <= operand_value_i;
      req_pos_q <= position_i;
    end
    if (commit) begin
      out_status_q <= res_status;
      out_value_q  <= res_value;
      out_fpos_q   <= res_fpos;
      out_count_q  <= cnt_ext[4:0];
      out_empty_q  <= (count_d == '0);
      out_full_q   <= (count_d == CW'(DEPTH));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_value_o   = out_value_q;
  assign found_position_o = out_fpos_q;
  assign element_count_o  = out_count_q;
  assign is_empty_o       = out_empty_q;
  assign is_full_o        = out_full_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");

  a_empty_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty deque with pointers off slot zero");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_wr_en)
    else $error("ram write outside execution");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> out_free)
    else $error("result overwrites one not yet transferred");
`endif

endmodule

// ===== verif/circular_deque_engine_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_engine_unit_test
// drives push, pop, read, search and update requests into the deque engine
// and checks every result against a behavioral deque kept in a scoreboard;
// runs directed corner cases, then random bursts biased to fill and drain
// ----------------------------------------------------------------------------
module circular_deque_engine_unit_test
  import cde_pkg::*;
();

  localparam int DEPTH          = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 370;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [3:0]  found_pos;
    logic [4:0]  count;
    logic        empty;
    logic        full;
  } deque_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         command;
  logic signed [31:0] operand_value;
  logic [3:0]         position;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic signed [31:0] result_value;
  logic [3:0]         found_position;
  logic [4:0]         element_count;
  logic               is_empty;
  logic               is_full;

  int in_idle_pct;
  int out_idle_pct;
  int quiet_cycles;

  class deque_scoreboard;
    logic [31:0]   slot_mem [DEPTH];
    int            head_idx;
    int            tail_idx;
    int            held;
    deque_result_t awaited [$];
    int            errors;
    int            result_idx;

    function new();
      head_idx   = 0;
      tail_idx   = 0;
      held       = 0;
      errors     = 0;
      result_idx = 0;
    endfunction

    function int count();
      return held;
    endfunction

    function logic [31:0] element_at(int k);
      return slot_mem[(head_idx + k) % DEPTH];
    endfunction

    // advance the deque by one request and queue the result it must produce
    function void note_request(cmd_e cmd, logic [31:0] val, logic [3:0] pos);
      deque_result_t exp;
      exp = '0;
      exp.status = STAT_OK;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (held >= DEPTH) begin
            exp.status = STAT_FULL;
          end else begin
            if (held == 0) begin
              head_idx    = 0;
              tail_idx    = 0;
              slot_mem[0] = val;
            end else if (cmd == CMD_PUSH_FRONT) begin
              head_idx           = (head_idx + DEPTH - 1) % DEPTH;
              slot_mem[head_idx] = val;
            end else begin
              tail_idx           = (tail_idx + 1) % DEPTH;
              slot_mem[tail_idx] = val;
            end
            held++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (held == 0) begin
            exp.status = STAT_EMPTY;
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              exp.value = slot_mem[head_idx];
              if (held > 1) head_idx = (head_idx + 1) % DEPTH;
            end else begin
              exp.value = slot_mem[tail_idx];
              if (held > 1) tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
            end
            held--;
            if (held == 0) begin
              head_idx = 0;
              tail_idx = 0;
            end
          end
        end
        CMD_READ_FRONT, CMD_READ_BACK: begin
          if (held == 0) exp.status = STAT_EMPTY;
          else exp.value = (cmd == CMD_READ_FRONT) ? slot_mem[head_idx] : slot_mem[tail_idx];
        end
        CMD_SEARCH: begin
          exp.status = STAT_NOT_FOUND;
          for (int k = 0; k < held; k++) begin
            if (element_at(k) == val) begin
              exp.status    = STAT_OK;
              exp.found_pos = k[3:0];
              break;
            end
          end
        end
        default: begin
          if (int'(pos) >= held) exp.status = STAT_BAD_INDEX;
          else slot_mem[(head_idx + int'(pos)) % DEPTH] = val;
        end
      endcase
      exp.count = held[4:0];
      exp.empty = (held == 0);
      exp.full  = (held == DEPTH);
      awaited = {awaited, exp};
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      errors++;
      if (errors <= 100)
        $display("[%0t] result %0d: %s got %0h expected %0h", $time, result_idx, what, got,
                 exp);
    endtask

    task check_result(deque_result_t got);
      deque_result_t exp;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, '0);
      end else begin
        exp = awaited[0];
        awaited.delete(0);
        if (got.status !== exp.status) report_mismatch("status", got.status, exp.status);
        if (got.value !== exp.value) report_mismatch("result_value", got.value, exp.value);
        if (got.found_pos !== exp.found_pos)
          report_mismatch("found_position", got.found_pos, exp.found_pos);
        if (got.count !== exp.count) report_mismatch("element_count", got.count, exp.count);
        if (got.empty !== exp.empty) report_mismatch("is_empty", got.empty, exp.empty);
        if (got.full !== exp.full) report_mismatch("is_full", got.full, exp.full);
      end
      result_idx++;
    endtask

    task check_drained();
      if (awaited.size() != 0) report_mismatch("results missing", awaited.size(), '0);
    endtask
  endclass

  deque_scoreboard sb;

  circular_deque_engine_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .operand_value_i (operand_value),
    .position_i      (position),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .result_value_o  (result_value),
    .found_position_o(found_position),
    .element_count_o (element_count),
    .is_empty_o      (is_empty),
    .is_full_o       (is_full)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({status, result_value, found_position, element_count, is_empty,
                       is_full});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold valid and payload until the transfer, then update the deque model
  task automatic send_request(cmd_e cmd, logic [31:0] val, logic [3:0] pos);
    @(negedge clk);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    operand_value <= val;
    position      <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, val, pos);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hffff_ffff;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      5:       return 32'h5a5a_a5a5;
      default: return $urandom;
    endcase
  endfunction

  // bursts that mostly fill, mostly drain, or mix, so full and empty come often
  task automatic run_random(int n);
    int   sent;
    int   mode;
    int   burst;
    cmd_e cmd;
    logic [31:0] val;
    logic [3:0]  pos;
    sent = 0;
    while (sent < n) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        if (mode == 0 && $urandom_range(99) < 80)
          cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (mode == 1 && $urandom_range(99) < 80)
          cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else
          cmd = cmd_e'($urandom_range(7));
        val = pick_value();
        pos = 4'($urandom);
        if (cmd == CMD_SEARCH && sb.count() > 0 && $urandom_range(99) < 60)
          val = sb.element_at($urandom_range(sb.count() - 1));
        if (cmd == CMD_UPDATE && sb.count() > 0 && $urandom_range(99) < 70)
          pos = 4'($urandom_range(sb.count() - 1));
        send_request(cmd, val, pos);
        sent++;
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    command       = CMD_PUSH_FRONT;
    operand_value = '0;
    position      = '0;
    out_ready     = 1'b0;
    quiet_cycles  = 0;
    in_idle_pct   = 36;
    out_idle_pct  = 81;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty deque corner cases
    send_request(CMD_POP_FRONT, 32'h1111_1111, 4'h0);
    send_request(CMD_POP_BACK, 32'h0, 4'hf);
    send_request(CMD_READ_FRONT, 32'h0, 4'h0);
    send_request(CMD_READ_BACK, 32'h0, 4'h0);
    send_request(CMD_SEARCH, 32'h0, 4'h0);
    send_request(CMD_UPDATE, 32'h0, 4'h0);
    // extreme values pushed at both ends, then searched, updated, read and popped
    send_request(CMD_PUSH_BACK, 32'h7fff_ffff, 4'h0);
    send_request(CMD_PUSH_FRONT, 32'h8000_0000, 4'hf);
    send_request(CMD_PUSH_BACK, 32'h0, 4'h0);
    send_request(CMD_PUSH_FRONT, 32'hffff_ffff, 4'h0);
    send_request(CMD_SEARCH, 32'h8000_0000, 4'h0);
    send_request(CMD_SEARCH, 32'h0, 4'h0);
    send_request(CMD_SEARCH, 32'h0001_2345, 4'h0);
    send_request(CMD_UPDATE, 32'h1234_5678, 4'h3);
    send_request(CMD_UPDATE, 32'h0, 4'h4);
    send_request(CMD_UPDATE, 32'h0, 4'hf);
    send_request(CMD_READ_FRONT, 32'h0, 4'h0);
    send_request(CMD_READ_BACK, 32'h0, 4'h0);
    send_request(CMD_POP_BACK, 32'h0, 4'h0);
    send_request(CMD_POP_FRONT, 32'h0, 4'h0);
    send_request(CMD_POP_BACK, 32'h0, 4'h0);
    send_request(CMD_POP_FRONT, 32'h0, 4'h0);
    send_request(CMD_POP_FRONT, 32'h0, 4'h0);

    run_random(PHASE_ITEMS);
    wait_results_done();
    in_idle_pct  = 81;
    out_idle_pct = 36;
    run_random(PHASE_ITEMS);
    wait_results_done();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(PHASE_ITEMS);

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
